FILE: hw/rtl/isst_pkg.sv
// Shared types and constants for the integer sample statistics block.
package isst_pkg;

  // Default sample and index widths, and the default depth of the item queue.
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int INDEX_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Fixed widths of the result fields.
  localparam int OUT_WIDTH = 32;
  localparam int ACC_WIDTH = 64;

  // Sample kind codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    KIND_VALID   = 2'd0,
    KIND_MISSING = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Classification of one item, decided in the front end.
  typedef struct packed {
    logic valid;
    logic missing;
    logic error;
    logic last;
  } cls_t;

  localparam int CLS_WIDTH = $bits(cls_t);

endpackage

FILE: hw/rtl/isst_front.sv
// Front end: accepts sample beats, classifies them and squares the sample.
module isst_front #(
  parameter int SAMPLE_WIDTH = isst_pkg::SAMPLE_WIDTH_DEF,
  parameter int INDEX_WIDTH  = isst_pkg::INDEX_WIDTH_DEF,
  parameter int ENTRY_WIDTH  = isst_pkg::CLS_WIDTH + 3 * SAMPLE_WIDTH + INDEX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     in_sample_value,
  input  logic        [31:0]     in_sample_index,
  input  logic        [1:0]      in_sample_kind,
  input  logic                   in_final_sample,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [ENTRY_WIDTH-1:0] push_data
);

  logic                           stg_vld_r, stg_vld_nxt;
  isst_pkg::cls_t                 stg_cls_r, cls_nxt;
  logic signed [SAMPLE_WIDTH-1:0] stg_val_r;
  logic        [INDEX_WIDTH-1:0]  stg_idx_r;
  logic signed [2*SAMPLE_WIDTH-1:0] stg_sq_r;
  logic signed [SAMPLE_WIDTH-1:0] val_in;
  logic                           load;

  assign val_in   = $signed(in_sample_value[SAMPLE_WIDTH-1:0]);
  assign in_ready = !stg_vld_r || push_ready;
  assign load     = in_valid && in_ready;

  // Classify the kind; the unused code counts as an error.
  always_comb begin
    cls_nxt = '0;
    cls_nxt.last = in_final_sample;
    case (in_sample_kind)
      isst_pkg::KIND_VALID:   cls_nxt.valid   = 1'b1;
      isst_pkg::KIND_MISSING: cls_nxt.missing = 1'b1;
      default:                cls_nxt.error   = 1'b1;
    endcase
  end

  // The stage holds its beat until the queue takes it.
  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (load) begin
      stg_vld_nxt = 1'b1;
    end else if (push_ready) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Payload registers, with the square taken on the way in.
  always_ff @(posedge clk) begin
    if (load) begin
      stg_cls_r <= cls_nxt;
      stg_val_r <= val_in;
      stg_idx_r <= in_sample_index[INDEX_WIDTH-1:0];
      stg_sq_r  <= val_in * val_in;
    end
  end

  assign push_valid = stg_vld_r;
  assign push_data  = {stg_cls_r, stg_val_r, stg_idx_r, stg_sq_r};

endmodule

FILE: hw/rtl/isst_queue.sv
// Small flip-flop queue between the front end and the back end.
module isst_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = isst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/isst_back.sv
// Back end: updates the accumulators and holds the result of each set.
module isst_back #(
  parameter int SAMPLE_WIDTH = isst_pkg::SAMPLE_WIDTH_DEF,
  parameter int INDEX_WIDTH  = isst_pkg::INDEX_WIDTH_DEF,
  parameter int ENTRY_WIDTH  = isst_pkg::CLS_WIDTH + 3 * SAMPLE_WIDTH + INDEX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [ENTRY_WIDTH-1:0] pop_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_any_valid,
  output logic [31:0]            out_valid_count,
  output logic signed [63:0]     out_total,
  output logic signed [63:0]     out_squares_total,
  output logic signed [31:0]     out_smallest,
  output logic signed [31:0]     out_largest,
  output logic [31:0]            out_smallest_position,
  output logic [31:0]            out_largest_position,
  output logic [31:0]            out_missing_count,
  output logic [31:0]            out_error_count
);

  localparam int OW = isst_pkg::OUT_WIDTH;
  localparam int AW = isst_pkg::ACC_WIDTH;
  localparam int SQ_W = 2 * SAMPLE_WIDTH;

  isst_pkg::cls_t                 cls;
  logic signed [SAMPLE_WIDTH-1:0] val;
  logic        [INDEX_WIDTH-1:0]  idx;
  logic        [SQ_W-1:0]         sq;

  logic                           seen_r, seen_nxt;
  logic [OW-1:0]                  cnt_r, cnt_nxt;
  logic [AW-1:0]                  sum_r, sum_nxt;
  logic [AW-1:0]                  sqs_r, sqs_nxt;
  logic signed [SAMPLE_WIDTH-1:0] min_r, min_nxt;
  logic signed [SAMPLE_WIDTH-1:0] max_r, max_nxt;
  logic [INDEX_WIDTH-1:0]         min_pos_r, min_pos_nxt;
  logic [INDEX_WIDTH-1:0]         max_pos_r, max_pos_nxt;
  logic [OW-1:0]                  miss_r, miss_nxt;
  logic [OW-1:0]                  err_r, err_nxt;

  logic                           ov_r, ov_nxt;
  logic                           o_any_r;
  logic [OW-1:0]                  o_cnt_r, o_miss_r, o_err_r, o_min_pos_r, o_max_pos_r;
  logic [AW-1:0]                  o_sum_r, o_sqs_r;
  logic signed [OW-1:0]           o_min_r, o_max_r;

  logic first, take_min, take_max, pop, emit;
  logic [AW-1:0] val_ext, sq_ext;

  assign {cls, val, idx, sq} = pop_data;

  // A final beat waits until the result register is free or being drained.
  assign pop_ready = !cls.last || !ov_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign emit      = pop && cls.last;

  // Next accumulator values, with the first valid sample seeding them.
  always_comb begin
    val_ext  = AW'(val);
    sq_ext   = AW'(sq);
    first    = cls.valid && !seen_r;
    take_min = first || (cls.valid && (val < min_r));
    take_max = first || (cls.valid && (val > max_r));
    seen_nxt = seen_r || cls.valid;
    cnt_nxt  = first ? OW'(1) : cnt_r + OW'(cls.valid);
    sum_nxt  = first ? val_ext : (cls.valid ? sum_r + val_ext : sum_r);
    sqs_nxt  = first ? sq_ext : (cls.valid ? sqs_r + sq_ext : sqs_r);
    min_nxt     = take_min ? val : min_r;
    min_pos_nxt = take_min ? idx : min_pos_r;
    max_nxt     = take_max ? val : max_r;
    max_pos_nxt = take_max ? idx : max_pos_r;
    miss_nxt = miss_r + OW'(cls.missing);
    err_nxt  = err_r + OW'(cls.error);
  end

  // Accumulators; a final beat clears them for the next set.
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      seen_r    <= 1'b0;
      cnt_r     <= '0;
      sum_r     <= '0;
      sqs_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      min_pos_r <= '0;
      max_pos_r <= '0;
      miss_r    <= '0;
      err_r     <= '0;
    end else if (pop) begin
      seen_r    <= seen_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      sqs_r     <= sqs_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      min_pos_r <= min_pos_nxt;
      max_pos_r <= max_pos_nxt;
      miss_r    <= miss_nxt;
      err_r     <= err_nxt;
    end
  end

  // Result valid flag.
  always_comb begin
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  // Result payload. With no valid sample the cleared accumulators read as zero.
  always_ff @(posedge clk) begin
    if (emit) begin
      o_any_r     <= seen_nxt;
      o_cnt_r     <= cnt_nxt;
      o_sum_r     <= sum_nxt;
      o_sqs_r     <= sqs_nxt;
      o_min_r     <= OW'(min_nxt);
      o_max_r     <= OW'(max_nxt);
      o_min_pos_r <= OW'(min_pos_nxt);
      o_max_pos_r <= OW'(max_pos_nxt);
      o_miss_r    <= miss_nxt;
      o_err_r     <= err_nxt;
    end
  end

  assign out_valid             = ov_r;
  assign out_any_valid         = o_any_r;
  assign out_valid_count       = o_cnt_r;
  assign out_total             = $signed(o_sum_r);
  assign out_squares_total     = $signed(o_sqs_r);
  assign out_smallest          = o_min_r;
  assign out_largest           = o_max_r;
  assign out_smallest_position = o_min_pos_r;
  assign out_largest_position  = o_max_pos_r;
  assign out_missing_count     = o_miss_r;
  assign out_error_count       = o_err_r;

`ifndef ASSERT_OFF
  // Once a set holds a valid sample, the minimum never exceeds the maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (min_r <= max_r))
    else $error("minimum above maximum");

  // Without a valid sample the valid accumulators stay cleared.
  a_clear_unseen: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (cnt_r == '0) && (sum_r == '0) && (sqs_r == '0))
    else $error("accumulators not clear before first valid sample");

  // A final beat clears the set and raises the result.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> !seen_r && (miss_r == '0) && (err_r == '0) && ov_r)
    else $error("final beat did not clear state or raise result");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |-> !emit)
    else $error("result overwritten while stalled");
`endif

endmodule

FILE: hw/rtl/integer_sample_statistics.sv
// Top level of the integer sample statistics block.
//
// Input channel (in_valid / in_ready): one sample beat per cycle while
// in_ready is high, carrying value, index, kind and a final flag. Only the
// low SAMPLE_WIDTH bits of the value (two's complement) and the low
// INDEX_WIDTH bits of the index count. Output channel (out_valid /
// out_ready): one result beat per set, raised after the beat flagged final,
// with count, wrapping sum and sum of squares, minimum and maximum with
// their first positions, and missing and error counts. The beat that carries
// the final flag is included in its result. The single multiply sits in the
// front stage and the 64-bit accumulate in the back end. A final beat passes
// through the front stage register and the queue, then the back end
// registers the result and raises out_valid.
// The front stage and back end are parted by a QUEUE_DEPTH entry queue, so
// samples keep flowing while a result waits; only a further final beat must
// wait for the pending result to be taken, and meanwhile the queue fills
// behind it and in_ready drops.
// Reset (rst_n low, synchronous) empties the pipeline and clears all
// accumulators; no clearing pass follows.
module integer_sample_statistics #(
  parameter int SAMPLE_WIDTH = isst_pkg::SAMPLE_WIDTH_DEF,
  parameter int INDEX_WIDTH  = isst_pkg::INDEX_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = isst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample_value,
  input  logic        [31:0] in_sample_index,
  input  logic        [1:0]  in_sample_kind,
  input  logic               in_final_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_any_valid,
  output logic [31:0]        out_valid_count,
  output logic signed [63:0] out_total,
  output logic signed [63:0] out_squares_total,
  output logic signed [31:0] out_smallest,
  output logic signed [31:0] out_largest,
  output logic [31:0]        out_smallest_position,
  output logic [31:0]        out_largest_position,
  output logic [31:0]        out_missing_count,
  output logic [31:0]        out_error_count
);

  localparam int ENTRY_WIDTH = isst_pkg::CLS_WIDTH + 3 * SAMPLE_WIDTH + INDEX_WIDTH;

  logic                   push_valid, push_ready;
  logic [ENTRY_WIDTH-1:0] push_data;
  logic                   pop_valid, pop_ready;
  logic [ENTRY_WIDTH-1:0] pop_data;

  // Classification and squaring.
  isst_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .INDEX_WIDTH  (INDEX_WIDTH),
    .ENTRY_WIDTH  (ENTRY_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .in_sample_index (in_sample_index),
    .in_sample_kind  (in_sample_kind),
    .in_final_sample (in_final_sample),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  // Decoupling queue.
  isst_queue #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  // Accumulation and result register.
  isst_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .INDEX_WIDTH  (INDEX_WIDTH),
    .ENTRY_WIDTH  (ENTRY_WIDTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pop_valid             (pop_valid),
    .pop_ready             (pop_ready),
    .pop_data              (pop_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_any_valid         (out_any_valid),
    .out_valid_count       (out_valid_count),
    .out_total             (out_total),
    .out_squares_total     (out_squares_total),
    .out_smallest          (out_smallest),
    .out_largest           (out_largest),
    .out_smallest_position (out_smallest_position),
    .out_largest_position  (out_largest_position),
    .out_missing_count     (out_missing_count),
    .out_error_count       (out_error_count)
  );

endmodule

FILE: tb/isst_stats_checker.sv
// Checker for the integer sample statistics block: predicts set totals and compares result beats.
`timescale 1ns / 100ps

module isst_stats_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_sample_value,
  input  logic        [31:0] in_sample_index,
  input  logic        [1:0]  in_sample_kind,
  input  logic               in_final_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_any_valid,
  input  logic [31:0]        out_valid_count,
  input  logic signed [63:0] out_total,
  input  logic signed [63:0] out_squares_total,
  input  logic signed [31:0] out_smallest,
  input  logic signed [31:0] out_largest,
  input  logic [31:0]        out_smallest_position,
  input  logic [31:0]        out_largest_position,
  input  logic [31:0]        out_missing_count,
  input  logic [31:0]        out_error_count,
  output int                 fail_count,
  output int                 totals_pending
);

  // Totals of one finished set, as the block should report them.
  typedef struct packed {
    logic        any_valid;
    logic [31:0] valid_count;
    logic [63:0] total;
    logic [63:0] squares_total;
    logic [31:0] smallest;
    logic [31:0] largest;
    logic [31:0] smallest_position;
    logic [31:0] largest_position;
    logic [31:0] missing_count;
    logic [31:0] error_count;
  } set_totals_t;

  set_totals_t expected_totals[$];

  // Running statistics of the set in progress.
  logic               run_seen    = 1'b0;
  logic [31:0]        run_count   = '0;
  logic [63:0]        run_sum     = '0;
  logic [63:0]        run_sq_sum  = '0;
  logic signed [31:0] run_min     = '0;
  logic signed [31:0] run_max     = '0;
  logic [31:0]        run_min_pos = '0;
  logic [31:0]        run_max_pos = '0;
  logic [31:0]        run_missing = '0;
  logic [31:0]        run_errors  = '0;

  // Fold one sample beat into the running set; a final beat closes the set.
  task automatic accumulate_sample(input logic signed [31:0] value, input logic [31:0] index,
                                   input logic [1:0] kind, input logic last);
    logic signed [63:0] wide;
    logic [63:0]        square;
    set_totals_t        closed;
    wide   = value;
    square = wide * wide;
    if (kind == isst_pkg::KIND_VALID) begin
      if (!run_seen) begin
        run_seen    = 1'b1;
        run_count   = 32'd1;
        run_sum     = wide;
        run_sq_sum  = square;
        run_min     = value;
        run_max     = value;
        run_min_pos = index;
        run_max_pos = index;
      end else begin
        run_count  = run_count + 32'd1;
        run_sum    = run_sum + wide;
        run_sq_sum = run_sq_sum + square;
        // Strict compares keep the earlier index on a tie.
        if (value < run_min) begin
          run_min     = value;
          run_min_pos = index;
        end
        if (value > run_max) begin
          run_max     = value;
          run_max_pos = index;
        end
      end
    end else if (kind == isst_pkg::KIND_MISSING) begin
      run_missing = run_missing + 32'd1;
    end else begin
      // The unused kind code is counted as an error too.
      run_errors = run_errors + 32'd1;
    end

    if (last) begin
      closed = '0;
      if (run_seen) begin
        closed.any_valid         = 1'b1;
        closed.valid_count       = run_count;
        closed.total             = run_sum;
        closed.squares_total     = run_sq_sum;
        closed.smallest          = run_min;
        closed.largest           = run_max;
        closed.smallest_position = run_min_pos;
        closed.largest_position  = run_max_pos;
      end
      closed.missing_count = run_missing;
      closed.error_count   = run_errors;
      expected_totals.push_back(closed);
      run_seen    = 1'b0;
      run_count   = '0;
      run_sum     = '0;
      run_sq_sum  = '0;
      run_min     = '0;
      run_max     = '0;
      run_min_pos = '0;
      run_max_pos = '0;
      run_missing = '0;
      run_errors  = '0;
    end
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Watch both channels at every edge.
  always @(posedge clk) begin
    int          delta;
    set_totals_t want;
    delta = 0;
    if (!rst_n) begin
      totals_pending <= 0;
    end else begin
      // Compare a result beat with the oldest set still waiting.
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no set pending, actual total %0h", $time, out_total);
        end else begin
          want = expected_totals.pop_front();
          delta--;
          check_field("any_valid", 64'(want.any_valid), 64'(out_any_valid));
          check_field("valid_count", 64'(want.valid_count), 64'(out_valid_count));
          check_field("total", want.total, out_total);
          check_field("squares_total", want.squares_total, out_squares_total);
          check_field("smallest", 64'(want.smallest), 64'($unsigned(out_smallest)));
          check_field("largest", 64'(want.largest), 64'($unsigned(out_largest)));
          check_field("smallest_position", 64'(want.smallest_position),
                      64'(out_smallest_position));
          check_field("largest_position", 64'(want.largest_position),
                      64'(out_largest_position));
          check_field("missing_count", 64'(want.missing_count), 64'(out_missing_count));
          check_field("error_count", 64'(want.error_count), 64'(out_error_count));
        end
      end
      // Predict from each accepted sample beat.
      if (in_valid && in_ready) begin
        accumulate_sample(in_sample_value, in_sample_index, in_sample_kind, in_final_sample);
        if (in_final_sample) delta++;
      end
      totals_pending <= totals_pending + delta;
    end
  end

endmodule

FILE: tb/tb_integer_sample_statistics.sv
// Testbench top for the integer sample statistics block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_integer_sample_statistics;

  // The kind code that the package leaves unnamed; the block treats it as an error.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam int TOTAL_ITEMS = 1100;
  localparam int CALM_FROM   = 950;
  localparam int HOLD_AT     = 300;
  localparam int DRAIN_AT    = 550;
  localparam int LONG_HOLD   = 120;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_sample_value;
  logic        [31:0] in_sample_index;
  logic        [1:0]  in_sample_kind;
  logic               in_final_sample;
  logic               out_valid;
  logic               out_ready;
  logic               out_any_valid;
  logic [31:0]        out_valid_count;
  logic signed [63:0] out_total;
  logic signed [63:0] out_squares_total;
  logic signed [31:0] out_smallest;
  logic signed [31:0] out_largest;
  logic [31:0]        out_smallest_position;
  logic [31:0]        out_largest_position;
  logic [31:0]        out_missing_count;
  logic [31:0]        out_error_count;

  int fail_count;
  int totals_pending;
  int items_sent   = 0;
  bit calm_tail    = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  integer_sample_statistics uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_value      (in_sample_value),
    .in_sample_index      (in_sample_index),
    .in_sample_kind       (in_sample_kind),
    .in_final_sample      (in_final_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_any_valid        (out_any_valid),
    .out_valid_count      (out_valid_count),
    .out_total            (out_total),
    .out_squares_total    (out_squares_total),
    .out_smallest         (out_smallest),
    .out_largest          (out_largest),
    .out_smallest_position(out_smallest_position),
    .out_largest_position (out_largest_position),
    .out_missing_count    (out_missing_count),
    .out_error_count      (out_error_count)
  );

  isst_stats_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_value      (in_sample_value),
    .in_sample_index      (in_sample_index),
    .in_sample_kind       (in_sample_kind),
    .in_final_sample      (in_final_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_any_valid        (out_any_valid),
    .out_valid_count      (out_valid_count),
    .out_total            (out_total),
    .out_squares_total    (out_squares_total),
    .out_smallest         (out_smallest),
    .out_largest          (out_largest),
    .out_smallest_position(out_smallest_position),
    .out_largest_position (out_largest_position),
    .out_missing_count    (out_missing_count),
    .out_error_count      (out_error_count),
    .fail_count           (fail_count),
    .totals_pending       (totals_pending)
  );

  // Offer one sample beat, hold it until accepted, then maybe idle for a burst.
  task automatic send_sample(input logic [31:0] value, input logic [31:0] index,
                             input logic [1:0] kind, input logic last);
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_sample_index <= index;
    in_sample_kind  <= kind;
    in_final_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop offering beats until every pending set has been reported.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (totals_pending != 0) @(posedge clk);
  endtask

  // Sample values lean on the extremes and on small values that tie often.
  function automatic logic [31:0] pick_value();
    logic [31:0] near_zero;
    near_zero = $urandom_range(0, 40);
    case ($urandom_range(0, 7))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2, 3:    return near_zero - 32'd20;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_kind(input bit valid_rare);
    int roll;
    roll = $urandom_range(0, 19);
    if (!valid_rare && roll < 14) return isst_pkg::KIND_VALID;
    if (valid_rare && roll < 2)   return isst_pkg::KIND_VALID;
    if (roll < 17)                return isst_pkg::KIND_MISSING;
    if (roll < 19)                return isst_pkg::KIND_ERROR;
    return KIND_UNUSED;
  endfunction

  // One set of samples with mostly ascending indexes; the last beat is final.
  task automatic send_random_set(input int len);
    logic [31:0] index;
    bit          valid_rare;
    valid_rare = ($urandom_range(0, 7) == 0);
    for (int i = 1; i <= len; i++) begin
      index = ($urandom_range(0, 11) == 0) ? $urandom() : i;
      send_sample(pick_value(), index, pick_kind(valid_rare), i == len);
    end
  endtask

  // Receiver: ready bursts, stall bursts, one long hold on request, none at the tail.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #400000;
    $display("[integer_sample_statistics] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    bit held;
    bit drained;
    int len;
    held            = 1'b0;
    drained         = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    in_sample_index = '0;
    in_sample_kind  = isst_pkg::KIND_VALID;
    in_final_sample = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A set of one sample: the final beat alone seeds everything.
    send_sample(INT_MIN, 32'd1, isst_pkg::KIND_VALID, 1'b1);
    // Both extremes in one set.
    send_sample(INT_MAX, 32'd1, isst_pkg::KIND_VALID, 1'b0);
    send_sample(INT_MIN, 32'd2, isst_pkg::KIND_VALID, 1'b0);
    send_sample(32'd0, 32'd3, isst_pkg::KIND_VALID, 1'b1);
    // No valid sample at all, with the unused kind among the entries.
    send_sample(32'd123, 32'd1, isst_pkg::KIND_MISSING, 1'b0);
    send_sample(32'd0, 32'd2, isst_pkg::KIND_ERROR, 1'b0);
    send_sample(32'hDEAD_BEEF, 32'd3, KIND_UNUSED, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'd4, isst_pkg::KIND_MISSING, 1'b1);
    // Ties on minimum and maximum keep the first index.
    send_sample(32'd5, 32'd10, isst_pkg::KIND_VALID, 1'b0);
    send_sample(32'd5, 32'd11, isst_pkg::KIND_VALID, 1'b0);
    send_sample(-32'sd5, 32'd12, isst_pkg::KIND_VALID, 1'b0);
    send_sample(-32'sd5, 32'd13, isst_pkg::KIND_VALID, 1'b0);
    send_sample(32'd5, 32'd14, isst_pkg::KIND_VALID, 1'b1);
    // Index zero and indexes out of order; the final beat is a missing entry.
    send_sample(32'd7, 32'd0, isst_pkg::KIND_VALID, 1'b0);
    send_sample(32'd3, 32'hFFFF_FFFF, isst_pkg::KIND_VALID, 1'b0);
    send_sample(32'd9, 32'd5, isst_pkg::KIND_VALID, 1'b0);
    send_sample(32'd1, 32'd2, isst_pkg::KIND_MISSING, 1'b1);
    // Four squares of the most negative value wrap the square sum to zero.
    for (int i = 1; i <= 4; i++) send_sample(INT_MIN, i, isst_pkg::KIND_VALID, 1'b0);
    send_sample(INT_MAX, 32'd5, isst_pkg::KIND_ERROR, 1'b1);

    // Random sets, mostly short, with a long receiver hold and a full drain.
    while (items_sent < TOTAL_ITEMS) begin
      if (!held && items_sent >= HOLD_AT) begin
        held         = 1'b1;
        hold_request = 1'b1;
        while (hold_request) send_random_set($urandom_range(1, 2));
      end
      if (!drained && items_sent >= DRAIN_AT) begin
        drained = 1'b1;
        drain_results();
      end
      calm_tail = (items_sent >= CALM_FROM);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
      send_random_set(len);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[integer_sample_statistics] OK");
    end else begin
      $display("[integer_sample_statistics] ERROR");
    end
    $finish;
  end

endmodule
